>>> src/delog_pkg.sv
// Shared types, sizes and helpers for the per-source deduplicating event log.
// Used by delog_ctrl, delog_datapath and dedup_event_log_per_source.
package delog_pkg;

  // Sizing of the log.
  localparam int EVENTS_PER_SOURCE = 4;
  localparam int NUM_SOURCES       = 256;
  localparam int COUNT_BITS        = 16;

  localparam int SRC_BITS  = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
  localparam int HEAD_BITS = (EVENTS_PER_SOURCE > 1) ? $clog2(EVENTS_PER_SOURCE) : 1;
  localparam int FILL_BITS = $clog2(EVENTS_PER_SOURCE + 1);

  // Port widths.
  localparam int FIELD_BITS   = 8;
  localparam int IN_DATA_BITS = 48;
  localparam int OUT_CNT_BITS = 16;
  localparam int HELD_BITS    = 3;
  localparam int OUT_DATA_BITS = 24;

  // One logged event.
  typedef struct packed {
    logic                  reason;
    logic [FIELD_BITS-1:0] instance_id;
    logic [FIELD_BITS-1:0] expected_type;
    logic [FIELD_BITS-1:0] expected_cmd;
    logic [FIELD_BITS-1:0] got_type;
    logic [FIELD_BITS-1:0] got_cmd;
    logic [COUNT_BITS-1:0] count;
  } slot_t;

  // One source's queue: ring pointers plus all of its slots.
  typedef struct packed {
    logic [HEAD_BITS-1:0]                head;
    logic [FILL_BITS-1:0]                fill;
    slot_t [EVENTS_PER_SOURCE-1:0]       slots;
  } row_t;

  typedef enum logic {
    ST_IDLE,
    ST_CALC
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;  // capture the input transfer and read its source row
    logic commit;  // write the row back and load the result register
  } dp_cmd_t;

  // Caps a stored count to the reported width.
  function automatic logic [OUT_CNT_BITS-1:0] cap_count(input logic [COUNT_BITS-1:0] c);
    logic [32:0] w;
    w = 33'(c);
    return (w > 33'd65535) ? {OUT_CNT_BITS{1'b1}} : w[OUT_CNT_BITS-1:0];
  endfunction

endpackage

>>> src/delog_ctrl.sv
// Controller for the event log: handshakes and the two-step item sequence.
// Depends on delog_pkg for the state and command types.
module delog_ctrl
  import delog_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    s_tvalid,
  output logic    s_tready,
  output logic    m_tvalid,
  input  logic    m_tready,
  output dp_cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   m_tvalid_next;

  // State and result-valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= m_tvalid_next;
    end
  end

  // Next state and commands. The result register frees up when it is empty
  // or its transfer completes in this cycle.
  always_comb begin
    state_next    = state;
    s_tready      = 1'b0;
    cmd.accept    = 1'b0;
    cmd.commit    = 1'b0;
    m_tvalid_next = m_tvalid & ~m_tready;
    unique case (state)
      ST_IDLE: begin
        s_tready   = 1'b1;
        cmd.accept = s_tvalid;
        if (s_tvalid) begin
          state_next = ST_CALC;
        end
      end
      ST_CALC: begin
        if (!m_tvalid || m_tready) begin
          cmd.commit    = 1'b1;
          m_tvalid_next = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/delog_datapath.sv
// Datapath for the event log: per-source queue memory, compare and update, result register.
// Depends on delog_pkg for the row layout and sizes.
module delog_datapath
  import delog_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  dp_cmd_t                  cmd,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  input  logic                     s_tuser,
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  // Queue memory, one row per source, and valid bits that stand for the reset state.
  row_t                   mem [NUM_SOURCES];
  logic [NUM_SOURCES-1:0] row_valid;

  logic [SRC_BITS-1:0]   in_idx;
  logic                  in_ok;

  // Captured item.
  logic [SRC_BITS-1:0]   src;
  logic                  in_range;
  slot_t                 item;
  row_t                  rd_row;
  logic                  rd_valid;

  // Update results.
  row_t                  wr_row;
  logic                  dup;
  logic                  evict;
  logic [OUT_CNT_BITS-1:0] cnt_out;

  assign in_idx = s_tdata[SRC_BITS-1:0];
  assign in_ok  = ({1'b0, s_tdata[7:0]} < 9'(NUM_SOURCES));

  // Capture the item and read its source row on the accepting edge.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      src                <= in_idx;
      in_range           <= in_ok;
      item.reason        <= s_tuser;
      item.instance_id   <= s_tdata[15:8];
      item.expected_type <= s_tuser ? '0 : s_tdata[23:16];
      item.expected_cmd  <= s_tuser ? '0 : s_tdata[31:24];
      item.got_type      <= s_tdata[39:32];
      item.got_cmd       <= s_tdata[47:40];
      item.count         <= COUNT_BITS'(1);
      rd_row             <= mem[in_idx];
      rd_valid           <= row_valid[in_idx];
    end
  end

  // Write back the updated row.
  always_ff @(posedge clk) begin
    if (cmd.commit && in_range) begin
      mem[src] <= wr_row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
    end else if (cmd.commit && in_range) begin
      row_valid[src] <= 1'b1;
    end
  end

  // Compare against the live slots and build the updated row.
  always_comb begin
    logic [HEAD_BITS-1:0]         head;
    logic [FILL_BITS-1:0]         fill;
    logic [HEAD_BITS:0]           off;
    logic [EVENTS_PER_SOURCE-1:0] match;
    logic [HEAD_BITS-1:0]         sel;
    logic [COUNT_BITS-1:0]        sel_cnt;
    logic [COUNT_BITS-1:0]        inc_cnt;
    logic [FILL_BITS:0]           sum;
    logic [HEAD_BITS-1:0]         pos;
    logic                         full;

    head = rd_valid ? rd_row.head : '0;
    fill = rd_valid ? rd_row.fill : '0;

    // A slot is live when its distance from the head is below the fill.
    sel = '0;
    for (int j = EVENTS_PER_SOURCE - 1; j >= 0; j--) begin
      if ((HEAD_BITS+1)'(j) >= {1'b0, head}) begin
        off = (HEAD_BITS+1)'(j) - {1'b0, head};
      end else begin
        off = (HEAD_BITS+1)'(j) + (HEAD_BITS+1)'(EVENTS_PER_SOURCE) - {1'b0, head};
      end
      match[j] = (32'(off) < 32'(fill)) &&
                 (rd_row.slots[j].reason == item.reason) &&
                 (rd_row.slots[j].expected_type == item.expected_type) &&
                 (rd_row.slots[j].expected_cmd == item.expected_cmd) &&
                 (rd_row.slots[j].got_type == item.got_type) &&
                 (rd_row.slots[j].got_cmd == item.got_cmd);
      if (match[j]) begin
        sel = HEAD_BITS'(j);
      end
    end
    dup = |match;

    // Saturating count of the matched slot.
    sel_cnt = rd_row.slots[sel].count;
    inc_cnt = (sel_cnt == '1) ? sel_cnt : sel_cnt + COUNT_BITS'(1);

    // Insertion slot: the old head when full, else the slot after the newest.
    full = (32'(fill) == EVENTS_PER_SOURCE);
    sum  = (FILL_BITS+1)'(head) + (FILL_BITS+1)'(fill);
    if (full) begin
      pos = head;
    end else if (32'(sum) >= EVENTS_PER_SOURCE) begin
      pos = HEAD_BITS'(sum - (FILL_BITS+1)'(EVENTS_PER_SOURCE));
    end else begin
      pos = HEAD_BITS'(sum);
    end

    wr_row      = rd_row;
    wr_row.head = head;
    wr_row.fill = fill;
    evict       = 1'b0;
    if (dup) begin
      wr_row.slots[sel].count = inc_cnt;
      cnt_out = cap_count(inc_cnt);
    end else begin
      wr_row.slots[pos] = item;
      cnt_out = OUT_CNT_BITS'(1);
      if (full) begin
        evict = 1'b1;
        if (32'(head) == EVENTS_PER_SOURCE - 1) begin
          wr_row.head = '0;
        end else begin
          wr_row.head = head + HEAD_BITS'(1);
        end
      end else begin
        wr_row.fill = fill + FILL_BITS'(1);
      end
    end
  end

  // Result register; an out-of-range source reports all zeros.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (in_range) begin
        m_tdata <= {3'b000, HELD_BITS'(wr_row.fill), cnt_out, evict, dup};
      end else begin
        m_tdata <= '0;
      end
    end
  end

endmodule

>>> src/dedup_event_log_per_source.sv
// Top level of the per-source deduplicating event log.
// Depends on delog_pkg, delog_ctrl and delog_datapath.
//
// Usage:
//   Input channel s_*: one response-mismatch event per transfer. The event
//   reason rides on s_tuser; the other fields are packed in s_tdata.
//   Output channel m_*: exactly one result transfer per input transfer, in
//   order, giving the duplicate and eviction flags, the entry's count and
//   the source's queue fill after the event.
//   Timing: the accepting edge reads the source's queue row from the row
//   memory into a register; in the calculate state all slots are compared
//   in parallel, and the edge that leaves it writes the row back and loads
//   the result register, raising m_tvalid. The controller accepts no new
//   item until the current item's row has been written back.
//   Reset: clears the controller and the per-source valid bits, so every
//   queue reads as empty at once; no clearing pass runs.
//   Stall: a result waits in the output register while the next item is
//   accepted and read; that item's write-back waits until the register frees.
module dedup_event_log_per_source
  import delog_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // source_id[7:0], instance_id[15:8], expected_type[23:16],
  // expected_cmd[31:24], got_type[39:32], got_cmd[47:40]
  input  logic [IN_DATA_BITS-1:0]  s_tdata,
  // reason[0]
  input  logic                     s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // was_duplicate[0], evicted_oldest[1], occurrence_count[17:2],
  // entries_held[20:18], zero fill[23:21]
  output logic [OUT_DATA_BITS-1:0] m_tdata
);

  dp_cmd_t cmd;

  delog_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  delog_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tdata (m_tdata)
  );

endmodule
